// ===== hdl/divider_timer_and_rtc_tick_core_assert.svh =====
// assertion macros shared by dtrt_state and the divider, timer and clock tick core
`ifndef DIVIDER_TIMER_AND_RTC_TICK_CORE_ASSERT_SVH
`define DIVIDER_TIMER_AND_RTC_TICK_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// clocked check, masked while reset is active
`define DTRT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define DTRT_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DTRT_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define DTRT_ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/dtrt_pkg.sv =====
// types and constants for the divider, timer and clock tick block
package dtrt_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_RELOAD_VALUE = 2'd0;
  localparam logic [1:0] REG_TIMER_ENABLE = 2'd1;
  localparam logic [1:0] REG_TIMER_PERIOD = 2'd2;
  localparam logic [1:0] REG_RTC_ENABLE   = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // accumulator widths and limits
  localparam int unsigned DIV_ACC_W = 9;
  localparam int unsigned TIM_ACC_W = 13;
  localparam int unsigned RTC_ACC_W = 21;

  localparam logic [DIV_ACC_W-1:0] DIV_STEP = 9'd64;
  localparam logic [RTC_ACC_W-1:0] RTC_STEP = 21'd1048576;

  localparam logic [12:0] TIMER_PERIOD_RST = 13'd1024;

  // clock limits
  localparam logic [5:0] SEC_LAST  = 6'd59;
  localparam logic [5:0] MIN_LAST  = 6'd59;
  localparam logic [4:0] HOUR_LAST = 5'd23;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef struct packed {
    logic [7:0]  reload_value;
    logic        timer_enable;
    logic [12:0] timer_period;
    logic        rtc_enable;
  } dtrt_cfg_t;

  typedef struct packed {
    logic [7:0] days;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } dtrt_clock_t;

  typedef struct packed {
    logic [7:0]  div_value;
    logic [7:0]  timer_value;
    logic        timer_irq;
    dtrt_clock_t clock;
  } dtrt_result_t;

endpackage

// ===== hdl/dtrt_rtc_cascade.sv =====
// cascaded seconds, minutes, hours and days stepping logic
module dtrt_rtc_cascade (
  input  logic                 step,
  input  dtrt_pkg::dtrt_clock_t cur,
  output dtrt_pkg::dtrt_clock_t nxt
);

  logic sec_wrap;
  logic min_wrap;
  logic hour_wrap;
  logic min_step;
  logic hour_step;
  logic day_step;

  // carry chain between the digits
  assign sec_wrap  = (cur.seconds >= dtrt_pkg::SEC_LAST);
  assign min_wrap  = (cur.minutes >= dtrt_pkg::MIN_LAST);
  assign hour_wrap = (cur.hours >= dtrt_pkg::HOUR_LAST);
  assign min_step  = step && sec_wrap;
  assign hour_step = min_step && min_wrap;
  assign day_step  = hour_step && hour_wrap;

  // next digit values
  always_comb begin
    nxt = cur;
    if (step) begin
      nxt.seconds = sec_wrap ? 6'd0 : cur.seconds + 6'd1;
    end
    if (min_step) begin
      nxt.minutes = min_wrap ? 6'd0 : cur.minutes + 6'd1;
    end
    if (hour_step) begin
      nxt.hours = hour_wrap ? 5'd0 : cur.hours + 5'd1;
    end
    if (day_step) begin
      nxt.days = cur.days + 8'd1;
    end
  end

endmodule

// ===== hdl/dtrt_state.sv =====
// accumulators and counters of the divider, timer and clock, one update per tick
`include "divider_timer_and_rtc_tick_core_assert.svh"

module dtrt_state (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [5:0]             elapsed_cycles,
  input  dtrt_pkg::dtrt_cfg_t    cfg,
  output dtrt_pkg::dtrt_result_t res
);

  logic [dtrt_pkg::DIV_ACC_W-1:0] div_accum_r, div_accum_nxt;
  logic [dtrt_pkg::TIM_ACC_W-1:0] timer_accum_r, timer_accum_nxt;
  logic [dtrt_pkg::RTC_ACC_W-1:0] rtc_accum_r, rtc_accum_nxt;
  logic [7:0]                     div_count_r, div_count_nxt;
  logic [7:0]                     timer_count_r, timer_count_nxt;
  dtrt_pkg::dtrt_clock_t          clock_r, clock_nxt;

  logic [7:0]                     dt;
  logic [dtrt_pkg::DIV_ACC_W:0]   div_sum;
  logic [dtrt_pkg::DIV_ACC_W-1:0] div_sat;
  logic                           div_hit;
  logic [dtrt_pkg::TIM_ACC_W:0]   tim_sum;
  logic [dtrt_pkg::TIM_ACC_W-1:0] tim_sat;
  logic                           tim_hit;
  logic                           tim_wrap;
  logic [dtrt_pkg::RTC_ACC_W:0]   rtc_sum;
  logic [dtrt_pkg::RTC_ACC_W-1:0] rtc_sat;
  logic                           rtc_hit;
  logic                           irq;

  // elapsed count scaled by four
  assign dt = {elapsed_cycles, 2'b00};

  // divider: saturating add, step when strictly above 64
  assign div_sum = {1'b0, div_accum_r} + {{(dtrt_pkg::DIV_ACC_W-7){1'b0}}, dt};
  assign div_sat = div_sum[dtrt_pkg::DIV_ACC_W] ? '1 : div_sum[dtrt_pkg::DIV_ACC_W-1:0];
  assign div_hit = (div_sat > dtrt_pkg::DIV_STEP);
  assign div_accum_nxt = div_hit ? div_sat - dtrt_pkg::DIV_STEP : div_sat;
  assign div_count_nxt = div_hit ? div_count_r + 8'd1 : div_count_r;

  // timer: saturating add, step when strictly above the period
  assign tim_sum  = {1'b0, timer_accum_r} + {{(dtrt_pkg::TIM_ACC_W-7){1'b0}}, dt};
  assign tim_sat  = tim_sum[dtrt_pkg::TIM_ACC_W] ? '1 : tim_sum[dtrt_pkg::TIM_ACC_W-1:0];
  assign tim_hit  = cfg.timer_enable && (tim_sat > cfg.timer_period);
  assign tim_wrap = (timer_count_r == 8'hFF);
  assign irq      = tim_hit && tim_wrap;

  always_comb begin
    timer_accum_nxt = timer_accum_r;
    timer_count_nxt = timer_count_r;
    if (cfg.timer_enable) begin
      timer_accum_nxt = tim_hit ? tim_sat - cfg.timer_period : tim_sat;
    end
    if (tim_hit) begin
      timer_count_nxt = tim_wrap ? cfg.reload_value : timer_count_r + 8'd1;
    end
  end

  // clock: saturating add, step on reaching one full period
  assign rtc_sum = {1'b0, rtc_accum_r} + {{(dtrt_pkg::RTC_ACC_W-7){1'b0}}, dt};
  assign rtc_sat = rtc_sum[dtrt_pkg::RTC_ACC_W] ? '1 : rtc_sum[dtrt_pkg::RTC_ACC_W-1:0];
  assign rtc_hit = cfg.rtc_enable && (rtc_sat >= dtrt_pkg::RTC_STEP);

  always_comb begin
    rtc_accum_nxt = rtc_accum_r;
    if (cfg.rtc_enable) begin
      rtc_accum_nxt = rtc_hit ? rtc_sat - dtrt_pkg::RTC_STEP : rtc_sat;
    end
  end

  dtrt_rtc_cascade u_cascade (
    .step (rtc_hit),
    .cur  (clock_r),
    .nxt  (clock_nxt)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_accum_r   <= '0;
      timer_accum_r <= '0;
      rtc_accum_r   <= '0;
      div_count_r   <= '0;
      timer_count_r <= '0;
      clock_r       <= '0;
    end else if (step) begin
      div_accum_r   <= div_accum_nxt;
      timer_accum_r <= timer_accum_nxt;
      rtc_accum_r   <= rtc_accum_nxt;
      div_count_r   <= div_count_nxt;
      timer_count_r <= timer_count_nxt;
      clock_r       <= clock_nxt;
    end
  end

  // values after this tick
  assign res.div_value   = div_count_nxt;
  assign res.timer_value = timer_count_nxt;
  assign res.timer_irq   = irq;
  assign res.clock       = clock_nxt;

  // checks
  `DTRT_ASSERT_RST(a_clock_range, clk, rst_n, (clock_r.seconds <= dtrt_pkg::SEC_LAST) && (clock_r.minutes <= dtrt_pkg::MIN_LAST) && (clock_r.hours <= dtrt_pkg::HOUR_LAST), "clock digit out of range")
  `DTRT_ASSERT_RST(a_div_hold, clk, rst_n, !step |=> (div_count_r == $past(div_count_r)) && (div_accum_r == $past(div_accum_r)), "divider moved without a tick")
  `DTRT_ASSERT_RST(a_timer_hold, clk, rst_n, (step && !cfg.timer_enable) |=> (timer_count_r == $past(timer_count_r)) && (timer_accum_r == $past(timer_accum_r)), "disabled timer moved")

endmodule

// ===== hdl/divider_timer_and_rtc_tick_core.sv =====
// divider, timer and clock tick block: an accepted tick passes through the input register and
// the result register; throughput one tick word per cycle while the output is not stalled;
// the state update is a single pass between the input and result registers, with stored
// state fed back on each tick; synchronous active-low reset clears all accumulators,
// counters, valid flags and configuration (timer period resets to 1024, everything else to zero)
`include "divider_timer_and_rtc_tick_core_assert.svh"

module divider_timer_and_rtc_tick_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [dtrt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtrt_pkg::CFG_DATA_W-1:0]     cfg_data,
  // tick input
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dtrt_pkg::IN_TDATA_W-1:0]     in_tdata,   // [5:0] elapsed_cycles
  // result output
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] div_value, [15:8] timer_value, [21:16] rtc_seconds, [27:22] rtc_minutes,
  // [32:28] rtc_hours, [40:33] rtc_days
  output logic [dtrt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tuser   // [0] timer_irq
);

  dtrt_pkg::dtrt_cfg_t    cfg_r;
  dtrt_pkg::dtrt_result_t res;
  dtrt_pkg::dtrt_result_t out_r;
  logic                   s1_valid_r;
  logic [5:0]             s1_dt_r;
  logic                   out_valid_r;
  logic                   s1_adv;
  logic                   step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reload_value <= '0;
      cfg_r.timer_enable <= 1'b0;
      cfg_r.timer_period <= dtrt_pkg::TIMER_PERIOD_RST;
      cfg_r.rtc_enable   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtrt_pkg::REG_RELOAD_VALUE: cfg_r.reload_value <= cfg_data[7:0];
        dtrt_pkg::REG_TIMER_ENABLE: cfg_r.timer_enable <= cfg_data[0];
        dtrt_pkg::REG_TIMER_PERIOD: cfg_r.timer_period <= cfg_data[12:0];
        dtrt_pkg::REG_RTC_ENABLE:   cfg_r.rtc_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake: the input stage moves on whenever the result register is empty or its word is taken
  assign s1_adv    = !out_valid_r || out_tready;
  assign step      = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_dt_r <= in_tdata[5:0];
    end
  end

  dtrt_state u_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .elapsed_cycles (s1_dt_r),
    .cfg            (cfg_r),
    .res            (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  // output packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.timer_irq;
  assign out_tdata  = {7'd0, out_r.clock.days, out_r.clock.hours, out_r.clock.minutes,
                       out_r.clock.seconds, out_r.timer_value, out_r.div_value};

  // checks
  `DTRT_ASSERT_RST(a_rise_from_s1, clk, rst_n, $rose(out_valid_r) |-> $past(s1_valid_r), "result word without a tick in the input stage")
  `DTRT_ASSERT_RST(a_stall_full, clk, rst_n, !in_tready |-> (s1_valid_r && out_valid_r && !out_tready), "input stalled with room left")
  `DTRT_ASSERT_RST(a_step_fills, clk, rst_n, step |=> out_valid_r, "processed tick did not reach the result register")

endmodule

// ===== verif/divider_timer_and_rtc_tick_core_test.sv =====
`timescale 1ns / 1ps
// self-checking test of the divider, timer and clock tick core with its own state predictor

// predicted counter state and the queue of result words still owed by the block
class tick_scoreboard;
  // register copies, reset values
  logic [7:0]  reload_value = '0;
  logic        timer_enable = 1'b0;
  logic [12:0] timer_period = dtrt_pkg::TIMER_PERIOD_RST;
  logic        rtc_enable   = 1'b0;

  // accumulators and counters
  logic [dtrt_pkg::DIV_ACC_W-1:0] div_accum   = '0;
  logic [dtrt_pkg::TIM_ACC_W-1:0] timer_accum = '0;
  logic [dtrt_pkg::RTC_ACC_W-1:0] rtc_accum   = '0;
  logic [7:0]                     div_count   = '0;
  logic [7:0]                     timer_count = '0;
  dtrt_pkg::dtrt_clock_t          clock       = '0;

  dtrt_pkg::dtrt_result_t owed_words[$];

  int unsigned mismatches    = 0;
  int unsigned words_checked = 0;
  int unsigned ticks_noted   = 0;
  int unsigned overflows     = 0;
  int unsigned second_steps  = 0;

  function int unsigned pending();
    return owed_words.size();
  endfunction

  function void write_reg(logic [dtrt_pkg::CFG_IDX_W-1:0] idx,
                          logic [dtrt_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      dtrt_pkg::REG_RELOAD_VALUE: reload_value = data[7:0];
      dtrt_pkg::REG_TIMER_ENABLE: timer_enable = data[0];
      dtrt_pkg::REG_TIMER_PERIOD: timer_period = data[12:0];
      dtrt_pkg::REG_RTC_ENABLE:   rtc_enable   = data[0];
      default: ;
    endcase
  endfunction

  // advance all counters by one tick and queue the word the block owes
  function void note_tick(logic [5:0] elapsed);
    int unsigned scaled;
    int unsigned sum;
    dtrt_pkg::dtrt_result_t word;
    scaled = int'(elapsed) * 4;
    word.timer_irq = 1'b0;
    ticks_noted++;

    // divider: saturating add, one step when strictly above 64
    sum = div_accum + scaled;
    if (sum > (1 << dtrt_pkg::DIV_ACC_W) - 1) sum = (1 << dtrt_pkg::DIV_ACC_W) - 1;
    if (sum > dtrt_pkg::DIV_STEP) begin
      sum -= dtrt_pkg::DIV_STEP;
      div_count++;
    end
    div_accum = sum[dtrt_pkg::DIV_ACC_W-1:0];

    // timer: holds when disabled, reloads on wrap
    if (timer_enable) begin
      sum = timer_accum + scaled;
      if (sum > (1 << dtrt_pkg::TIM_ACC_W) - 1) sum = (1 << dtrt_pkg::TIM_ACC_W) - 1;
      if (sum > timer_period) begin
        sum -= timer_period;
        timer_count++;
        if (timer_count == 8'd0) begin
          timer_count = reload_value;
          word.timer_irq = 1'b1;
          overflows++;
        end
      end
      timer_accum = sum[dtrt_pkg::TIM_ACC_W-1:0];
    end

    // clock: one second per 2^20 scaled elapsed units, cascading up to days
    if (rtc_enable) begin
      sum = rtc_accum + scaled;
      if (sum >= dtrt_pkg::RTC_STEP) begin
        sum -= dtrt_pkg::RTC_STEP;
        second_steps++;
        clock.seconds = (clock.seconds >= dtrt_pkg::SEC_LAST) ? 6'd0 : clock.seconds + 6'd1;
        if (clock.seconds == 6'd0) begin
          clock.minutes = (clock.minutes >= dtrt_pkg::MIN_LAST) ? 6'd0 : clock.minutes + 6'd1;
          if (clock.minutes == 6'd0) begin
            clock.hours = (clock.hours >= dtrt_pkg::HOUR_LAST) ? 5'd0 : clock.hours + 5'd1;
            if (clock.hours == 5'd0) clock.days = clock.days + 8'd1;
          end
        end
      end
      rtc_accum = sum[dtrt_pkg::RTC_ACC_W-1:0];
    end

    word.div_value   = div_count;
    word.timer_value = timer_count;
    word.clock       = clock;
    owed_words.push_back(word);
  endfunction

  function void field_check(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on word %0d, %s: expected %0d, got %0d",
                 words_checked, name, want, got);
    end
  endfunction

  // compare one accepted result word against the oldest prediction
  function void check_word(logic [dtrt_pkg::OUT_TDATA_W-1:0] tdata, logic tuser);
    dtrt_pkg::dtrt_result_t want;
    if (owed_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result word with nothing predicted: tdata %h tuser %b", tdata, tuser);
      return;
    end
    want = owed_words.pop_front();
    field_check("div_value",   want.div_value,     tdata[7:0]);
    field_check("timer_value", want.timer_value,   tdata[15:8]);
    field_check("timer_irq",   want.timer_irq,     tuser);
    field_check("rtc_seconds", want.clock.seconds, tdata[21:16]);
    field_check("rtc_minutes", want.clock.minutes, tdata[27:22]);
    field_check("rtc_hours",   want.clock.hours,   tdata[32:28]);
    field_check("rtc_days",    want.clock.days,    tdata[40:33]);
    field_check("tdata pad",   0,                  tdata[47:41]);
    words_checked++;
  endfunction
endclass

module divider_timer_and_rtc_tick_core_test;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned PHASE_TICKS  = 130;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [dtrt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dtrt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [dtrt_pkg::IN_TDATA_W-1:0] in_tdata = '0;   // [5:0] elapsed_cycles
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [7:0] div_value, [15:8] timer_value, [21:16] rtc_seconds, [27:22] rtc_minutes,
  // [32:28] rtc_hours, [40:33] rtc_days
  logic [dtrt_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;                        // [0] timer_irq

  tick_scoreboard sb = new();

  bit sender_idles = 1'b0;
  bit sink_idles = 1'b0;
  bit hold_request = 1'b0;
  int unsigned cycle_count = 0;

  divider_timer_and_rtc_tick_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count, sb.pending());
      $display("** divider_timer_and_rtc_tick_core: FAILED **");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // elapsed counts biased toward the ends of the range
  function automatic logic [5:0] pick_elapsed();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 6'd63;
    if (r < 25) return 6'd0;
    if (r < 40) return 6'($urandom_range(0, 3));
    return 6'($urandom_range(0, 63));
  endfunction

  // result sink: random stalls plus one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = sink_idles ? idle_len() : 0;
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser);
  end

  task automatic cfg_write(input logic [dtrt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dtrt_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // offer one tick word and hold it until accepted
  task automatic send_tick(input logic [5:0] elapsed);
    int unsigned gap;
    @(negedge clk);
    in_tdata  <= {2'b00, elapsed};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_tick(elapsed);
    gap = sender_idles ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop offering and wait until every owed word has come back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic cfg_all(input logic [7:0] reload, input logic ten,
                         input logic [12:0] period, input logic ren);
    cfg_write(dtrt_pkg::REG_RELOAD_VALUE, {5'd0, reload});
    cfg_write(dtrt_pkg::REG_TIMER_ENABLE, {12'd0, ten});
    cfg_write(dtrt_pkg::REG_TIMER_PERIOD, period);
    cfg_write(dtrt_pkg::REG_RTC_ENABLE,   {12'd0, ren});
  endtask

  initial begin : stimulus
    logic [7:0]  reloads [8];
    logic [12:0] periods [8];
    logic        timer_ons [8];

    reloads   = '{8'd250, 8'd0, 8'd255, 8'($urandom), 8'd200, 8'($urandom), 8'd128, 8'd240};
    periods   = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd3, 13'd256,
                  13'($urandom_range(1, 4096)), 13'd2};
    timer_ons = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: divider threshold just at and above 64, then saturation
    send_tick(6'd16);
    send_tick(6'd0);
    send_tick(6'd1);
    send_tick(6'd0);
    repeat (6) send_tick(6'd63);
    drain();

    // smallest period with a zero-length tick, then zero period
    cfg_all(8'd252, 1'b1, 13'd1, 1'b1);
    send_tick(6'd63);
    send_tick(6'd0);
    send_tick(6'd2);
    send_tick(6'd63);
    drain();
    cfg_write(dtrt_pkg::REG_TIMER_PERIOD, 13'd0);
    send_tick(6'd0);
    send_tick(6'd1);
    send_tick(6'd63);
    drain();

    // timer and clock disabled: both hold
    cfg_all(8'd255, 1'b0, 13'd8191, 1'b0);
    send_tick(6'd63);
    send_tick(6'd42);
    send_tick(6'd21);
    drain();

    // random phases across register settings
    for (int p = 0; p < 8; p++) begin
      cfg_all(reloads[p], timer_ons[p], periods[p], 1'($urandom_range(1)));
      sender_idles = (p != 0);
      sink_idles   = (p != 0) && (p != 6);
      if (p == 2) hold_request = 1'b1;
      for (int i = 0; i < PHASE_TICKS; i++) begin
        if (p == 5 && i == PHASE_TICKS / 2) drain();
        send_tick(pick_elapsed());
      end
      drain();
    end

    $display("%0d ticks sent, %0d result words checked", sb.ticks_noted, sb.words_checked);
    $display("%0d timer overflows and %0d clock second steps predicted",
             sb.overflows, sb.second_steps);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** divider_timer_and_rtc_tick_core: PASSED **");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("** divider_timer_and_rtc_tick_core: FAILED **");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/dtrt_pkg.sv
hdl/dtrt_rtc_cascade.sv
hdl/dtrt_state.sv
hdl/divider_timer_and_rtc_tick_core.sv
verif/divider_timer_and_rtc_tick_core_test.sv
